[sv/gwm_pkg.sv]
// Package for the glob wildcard matcher.
// Holds the store size, symbol codes, item function codes and the cell link types.
// No dependencies.
`timescale 1ns / 1ps

package gwm_pkg;

  // Number of pattern cells (bytes the store can hold)
  localparam int MAX_PATTERN = 32;

  localparam logic [7:0] SYM_STAR     = 8'd42;
  localparam logic [7:0] SYM_QUESTION = 8'd63;

  // Function code carried by each input beat
  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_TEXT   = 2'd2,
    FN_END    = 2'd3
  } func_t;

  // Broadcast control, same for every cell
  typedef struct packed {
    logic       clear;   // drop pattern, rearm
    logic       append;  // store symbol at the tail, rearm
    logic       text;    // advance automaton by symbol
    logic       rearm;   // end of text
    logic [7:0] symbol;
  } ctrl_t;

  // Signals handed from one cell to its right neighbor
  typedef struct packed {
    logic head;   // set only into the first cell
    logic valid;  // left cell holds a pattern byte
    logic carry;  // star closure reaching this position
    logic fire;   // left cell consumed the text byte
  } link_t;

endpackage

[sv/gwm_item_if.sv]
// Input channel of the glob wildcard matcher: valid/ready plus func and symbol.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

[sv/gwm_result_if.sv]
// Result channel of the glob wildcard matcher: valid/ready plus the verdict bits.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

[sv/glob_wildcard_matcher.sv]
// Top level of the glob wildcard matcher: a row of pattern cells plus the
// final position, overflow flag and a two-entry result buffer.
// Depends on gwm_pkg, gwm_item_if, gwm_result_if and gwm_cell.
//
//   Channel  Dir  Fields                     Beat meaning
//   item     in   func[1:0], symbol[7:0]     clear / append / text byte / end
//   result   out  matched, pattern_overflow  verdict, one per end beat
//
// Each accepted input beat updates the row of cells at once for all positions,
// with star closure rippling cell to cell within the same cycle.
// A verdict appears on result the cycle after its end beat is accepted,
// unless an unread verdict still holds the output register; then it waits
// in the skid entry until that one is taken.
// Reset empties the pattern, clears overflow and arms position zero.
// Input stalls only when both result entries hold unread verdicts.
`timescale 1ns / 1ps

module glob_wildcard_matcher (
  input logic       clk,
  input logic       rst,
  gwm_item_if.sink  item,
  gwm_result_if.source result
);
  import gwm_pkg::*;

  localparam int N = MAX_PATTERN;

  func_t func;
  logic  accept;
  ctrl_t ctrl;

  link_t          links [0:N];
  logic [N-1:0]   cell_hit;
  logic [N-1:0]   valid_vec;

  logic act_final;
  logic closed_final;
  logic hit_final;
  logic hit;
  logic ovf;

  logic out_valid;
  logic out_matched;
  logic out_ovf;
  logic skid_valid;
  logic skid_matched;
  logic skid_ovf;
  logic push;
  logic pop;

  assign func   = func_t'(item.func);
  assign accept = item.valid && item.ready;

  // Decode the beat into broadcast control
  always_comb begin
    ctrl        = '0;
    ctrl.symbol = item.symbol;
    case (func)
      FN_CLEAR:  ctrl.clear  = accept;
      FN_APPEND: ctrl.append = accept;
      FN_TEXT:   ctrl.text   = accept;
      FN_END:    ctrl.rearm  = accept;
      default:   ctrl        = '0;
    endcase
  end

  assign links[0] = '{head: 1'b1, valid: 1'b1, carry: 1'b0, fire: 1'b0};

  // Row of pattern cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    gwm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (links[i]),
      .right (links[i+1]),
      .hit   (cell_hit[i])
    );
    assign valid_vec[i] = links[i+1].valid;
  end

  // Final position, reached when the whole stored pattern is consumed
  assign closed_final = act_final | links[N].carry;
  assign hit_final    = closed_final & links[N].valid;
  assign hit          = (|cell_hit) | hit_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_final <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      if (ctrl.text) begin
        act_final <= links[N].fire;
      end else if (ctrl.clear || ctrl.append || ctrl.rearm) begin
        act_final <= 1'b0;
      end
      if (ctrl.clear) begin
        ovf <= 1'b0;
      end else if (ctrl.append && links[N].valid) begin
        ovf <= 1'b1;
      end
    end
  end

  // Result register with one skid entry behind it
  assign push = ctrl.rearm;
  assign pop  = out_valid && result.ready;
  assign item.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_matched <= skid_matched;
        out_ovf     <= skid_ovf;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_matched <= hit;
        out_ovf     <= ovf;
      end else begin
        skid_matched <= hit;
        skid_ovf     <= ovf;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.matched          = out_matched;
  assign result.pattern_overflow = out_ovf;

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // At most one position can be the pattern end
  a_one_end: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cell_hit, hit_final}))
    else $error("more than one pattern end position active");

  // Occupied cells form a contiguous run from cell zero
  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("pattern cells not contiguous");

  // A clear beat empties the store
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (valid_vec == '0) && !ovf)
    else $error("clear did not empty the pattern");

endmodule

[sv/gwm_cell.sv]
// One pattern position of the matcher: stored byte, occupancy bit, active bit.
// Depends on gwm_pkg for the control and link structs.
`timescale 1ns / 1ps

module gwm_cell (
  input  logic          clk,
  input  logic          rst,
  input  gwm_pkg::ctrl_t ctrl,
  input  gwm_pkg::link_t left,
  output gwm_pkg::link_t right,
  output logic          hit
);
  import gwm_pkg::*;

  logic [7:0] sym;
  logic       valid;
  logic       act;

  logic closed;
  logic is_star;
  logic is_match;

  // Position activity after closing over stars to the left
  assign closed   = act | left.carry;
  assign is_star  = (sym == SYM_STAR);
  assign is_match = (sym == SYM_QUESTION) || (sym == ctrl.symbol);

  assign right.head  = 1'b0;
  assign right.valid = valid;
  assign right.carry = closed & valid & is_star;
  assign right.fire  = closed & valid & ~is_star & is_match;

  // This position is the pattern end
  assign hit = closed & left.valid & ~valid;

  // Pattern byte: written when this cell is the tail
  always_ff @(posedge clk) begin
    if (ctrl.append && left.valid && !valid) begin
      sym <= ctrl.symbol;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      act   <= left.head;
    end else begin
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (ctrl.append && left.valid) begin
        valid <= 1'b1;
      end
      if (ctrl.text) begin
        act <= (closed & valid & is_star) | left.fire;
      end else if (ctrl.clear || ctrl.append || ctrl.rearm) begin
        act <= left.head;
      end
    end
  end

endmodule
